FILE: rtl/agc_pkg.sv
// Shared types and constants for the adaptive gain control block.
package agc_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned HOLD_W   = 20;
  localparam int unsigned AVG_W    = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned MUL_B_W  = 17;
  localparam int unsigned MUL_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_STEPS = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 4'd3;

  localparam logic [COEF_W-1:0] TARGET_RST  = 16'd6554;
  localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd65470;
  localparam logic [COEF_W-1:0] RELEASE_RST = 16'd64881;
  localparam logic [HOLD_W-1:0] HOLD_RST    = 20'd0;

  localparam logic [MUL_B_W-1:0] AVG_KEEP = 17'd58982;
  localparam logic [MUL_B_W-1:0] AVG_NEW  = 17'd6554;
  localparam logic [MUL_B_W-1:0] COEF_ONE = 17'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_ONE = 24'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_MAX = 24'hFF_FFFF;
  localparam logic [AVG_W-1:0]   ROOT_BIT_TOP = 32'h4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_KEEP,
    ST_NEW,
    ST_SUM,
    ST_RINIT,
    ST_ROOT,
    ST_DCHK,
    ST_DIV,
    ST_GAIN,
    ST_GAIN2,
    ST_GAIN3,
    ST_MULO,
    ST_RND,
    ST_FIN
  } agc_state_t;

endpackage

FILE: rtl/adaptive_gain_control.sv
// RMS-based automatic gain control: bit-serial square root and divider, shared multiplier.
//
//  channel | ports                          | beat contents
//  --------+--------------------------------+-----------------------------------------
//  input   | in_tvalid/in_tready/in_tdata   | [15:0] sample_in
//  output  | out_tvalid/out_tready/out_tdata| [15:0] sample_out, [39:16] gain_now
//  config  | cfg_valid/cfg_ready            | cfg_index register, cfg_data value
//
// Per sample, the square root yields one root bit per cycle (16-bit root) and the divider
// one quotient bit per cycle (24-bit quotient); the divider is skipped at zero level or
// saturated gain. The first sample skips ST_NEW/ST_SUM, a running hold ST_GAIN2/ST_GAIN3.
// Reset (synchronous, rst_n low) restores default registers, gain 1.0 and an unseeded average.
// A stalled output beat holds in the output register; the next sample is accepted
// meanwhile and its work waits in the final step until the register frees up.
module adaptive_gain_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] sample_out, [39:16] gain_now
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [agc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [agc_pkg::CFG_DATA_W-1:0] cfg_data
);

  agc_pkg::agc_state_t state_r, state_nxt;

  logic [15:0] x_r, x_nxt;
  logic [15:0] target_r, target_nxt;
  logic [15:0] atk_r, atk_nxt;
  logic [15:0] rel_r, rel_nxt;
  logic [19:0] holdset_r, holdset_nxt;
  logic [31:0] avg_r, avg_nxt;
  logic        seeded_r, seeded_nxt;
  logic [23:0] gain_r, gain_nxt;
  logic [19:0] hold_r, hold_nxt;
  logic [30:0] p_r, p_nxt;
  logic [agc_pkg::MUL_W-1:0] acc_r, acc_nxt;
  logic [agc_pkg::MUL_W-1:0] mul_r, mul_nxt;
  logic [31:0] rv_r, rv_nxt;
  logic [31:0] root_r, root_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [23:0] nsr_r, nsr_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] req_r, req_nxt;
  logic [15:0] c_r, c_nxt;
  logic [41:0] s_r, s_nxt;
  logic [39:0] out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [agc_pkg::MUL_A_W-1:0] mul_a;
  logic [agc_pkg::MUL_B_W-1:0] mul_b;
  logic        x_neg;
  logic [15:0] mag;
  logic [15:0] rms;
  logic [31:0] rsum;
  logic [16:0] dv_t;
  logic [16:0] dv_diff;
  logic        dv_ge;
  logic [15:0] c_sel;
  logic [49:0] wsum;
  logic [41:0] sm;
  logic [25:0] y_full;
  logic [15:0] y_sat;

  assign x_neg = x_r[15];
  assign mag   = x_neg ? 16'(16'd0 - x_r) : x_r;
  assign rms   = root_r[15:0];
  assign rsum  = root_r + bit_r;
  assign dv_t    = {rem_r, nsr_r[23]};
  assign dv_ge   = dv_t >= {1'b0, rms};
  assign dv_diff = dv_t - {1'b0, rms};
  assign c_sel   = (req_r > gain_r) ? atk_r : rel_r;
  assign wsum    = {1'b0, acc_r} + {1'b0, mul_r} + 50'd32768;
  assign sm      = {2'b00, mul_r[39:0]};
  assign y_full  = s_r[41:16];

  always_comb begin
    if ($signed(y_full) > $signed(26'sd32767)) begin
      y_sat = 16'h7FFF;
    end else if ($signed(y_full) < $signed(-26'sd32768)) begin
      y_sat = 16'h8000;
    end else begin
      y_sat = y_full[15:0];
    end
  end

  assign in_tready  = (state_r == agc_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    target_nxt    = target_r;
    atk_nxt       = atk_r;
    rel_nxt       = rel_r;
    holdset_nxt   = holdset_r;
    avg_nxt       = avg_r;
    seeded_nxt    = seeded_r;
    gain_nxt      = gain_r;
    hold_nxt      = hold_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    rv_nxt        = rv_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    rem_nxt       = rem_r;
    nsr_nxt       = nsr_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    mul_a         = '0;
    mul_b         = '0;

    if (cfg_valid) begin
      case (cfg_index)
        agc_pkg::CFG_TARGET:  target_nxt  = cfg_data[15:0];
        agc_pkg::CFG_ATTACK:  atk_nxt     = cfg_data[15:0];
        agc_pkg::CFG_RELEASE: rel_nxt     = cfg_data[15:0];
        agc_pkg::CFG_HOLD:    holdset_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      agc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = in_tdata;
          state_nxt = agc_pkg::ST_SQ;
        end
      end
      agc_pkg::ST_SQ: begin
        mul_a     = {16'd0, mag};
        mul_b     = {1'b0, mag};
        state_nxt = agc_pkg::ST_KEEP;
      end
      agc_pkg::ST_KEEP: begin
        p_nxt = mul_r[30:0];
        mul_a = avg_r;
        mul_b = agc_pkg::AVG_KEEP;
        if (!seeded_r) begin
          // first sample seeds the average directly
          avg_nxt    = {1'b0, mul_r[30:0]};
          seeded_nxt = 1'b1;
          state_nxt  = agc_pkg::ST_RINIT;
        end else begin
          state_nxt = agc_pkg::ST_NEW;
        end
      end
      agc_pkg::ST_NEW: begin
        acc_nxt   = mul_r;
        mul_a     = {1'b0, p_r};
        mul_b     = agc_pkg::AVG_NEW;
        state_nxt = agc_pkg::ST_SUM;
      end
      agc_pkg::ST_SUM: begin
        avg_nxt   = wsum[47:16];
        state_nxt = agc_pkg::ST_RINIT;
      end
      agc_pkg::ST_RINIT: begin
        rv_nxt    = avg_r;
        root_nxt  = '0;
        bit_nxt   = agc_pkg::ROOT_BIT_TOP;
        state_nxt = agc_pkg::ST_ROOT;
      end
      agc_pkg::ST_ROOT: begin
        // one root bit per cycle
        if (rv_r >= rsum) begin
          rv_nxt   = rv_r - rsum;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = agc_pkg::ST_DCHK;
        end
      end
      agc_pkg::ST_DCHK: begin
        // target << 15 over rms overflows 24 bits iff target[15:9] >= rms
        if (rms == 16'd0) begin
          req_nxt   = agc_pkg::GAIN_ONE;
          state_nxt = agc_pkg::ST_GAIN;
        end else if ({9'd0, target_r[15:9]} >= rms) begin
          req_nxt   = agc_pkg::GAIN_MAX;
          state_nxt = agc_pkg::ST_GAIN;
        end else begin
          rem_nxt   = {9'd0, target_r[15:9]};
          nsr_nxt   = {target_r[8:0], 15'd0};
          cnt_nxt   = '0;
          state_nxt = agc_pkg::ST_DIV;
        end
      end
      agc_pkg::ST_DIV: begin
        rem_nxt = dv_ge ? dv_diff[15:0] : dv_t[15:0];
        nsr_nxt = {nsr_r[22:0], dv_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(agc_pkg::DIV_STEPS - 1)) begin
          req_nxt   = {nsr_r[22:0], dv_ge};
          state_nxt = agc_pkg::ST_GAIN;
        end
      end
      agc_pkg::ST_GAIN: begin
        mul_a = {8'd0, gain_r};
        mul_b = {1'b0, c_sel};
        c_nxt = c_sel;
        if (hold_r == 20'd0) begin
          state_nxt = agc_pkg::ST_GAIN2;
        end else begin
          state_nxt = agc_pkg::ST_MULO;
        end
      end
      agc_pkg::ST_GAIN2: begin
        acc_nxt   = mul_r;
        mul_a     = {8'd0, req_r};
        mul_b     = agc_pkg::COEF_ONE - {1'b0, c_r};
        state_nxt = agc_pkg::ST_GAIN3;
      end
      agc_pkg::ST_GAIN3: begin
        gain_nxt  = wsum[39:16];
        state_nxt = agc_pkg::ST_MULO;
      end
      agc_pkg::ST_MULO: begin
        mul_a     = {8'd0, gain_r};
        mul_b     = {1'b0, mag};
        state_nxt = agc_pkg::ST_RND;
      end
      agc_pkg::ST_RND: begin
        // restore the sign and add the rounding half
        s_nxt = (x_neg ? (42'd0 - sm) : sm) + 42'd32768;
        if (hold_r != 20'd0) begin
          hold_nxt = hold_r - 20'd1;
        end
        if (req_r < gain_r) begin
          hold_nxt = holdset_r;
        end
        state_nxt = agc_pkg::ST_FIN;
      end
      agc_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {gain_r, y_sat};
          out_valid_nxt = 1'b1;
          state_nxt     = agc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = agc_pkg::ST_IDLE;
      end
    endcase

    mul_nxt = agc_pkg::MUL_W'(mul_a) * agc_pkg::MUL_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= agc_pkg::ST_IDLE;
      target_r    <= agc_pkg::TARGET_RST;
      atk_r       <= agc_pkg::ATTACK_RST;
      rel_r       <= agc_pkg::RELEASE_RST;
      holdset_r   <= agc_pkg::HOLD_RST;
      avg_r       <= '0;
      seeded_r    <= 1'b0;
      gain_r      <= agc_pkg::GAIN_ONE;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      target_r    <= target_nxt;
      atk_r       <= atk_nxt;
      rel_r       <= rel_nxt;
      holdset_r   <= holdset_nxt;
      avg_r       <= avg_nxt;
      seeded_r    <= seeded_nxt;
      gain_r      <= gain_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    mul_r      <= mul_nxt;
    rv_r       <= rv_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    rem_r      <= rem_nxt;
    nsr_r      <= nsr_nxt;
    cnt_r      <= cnt_nxt;
    req_r      <= req_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: tb/tb_adaptive_gain_control.sv
// Self-checking testbench for the RMS-based adaptive gain control block.
module tb_adaptive_gain_control;
  import agc_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned HOLD_OFF_AT = 400;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd11;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 4'd15;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_now;
    logic [SAMPLE_W-1:0] sample_out;
  } agc_beat_t;

  class agc_checker;
    logic [COEF_W-1:0] tgt_lvl;
    logic [COEF_W-1:0] atk_coef;
    logic [COEF_W-1:0] rel_coef;
    logic [HOLD_W-1:0] hold_samples;
    logic [AVG_W-1:0]  power_avg;
    bit                seeded;
    logic [GAIN_W-1:0] gain_level;
    logic [HOLD_W-1:0] hold_cnt;
    agc_beat_t         expected_beats[$];
    int                errors;
    int                checked;

    function new();
      tgt_lvl       = TARGET_RST;
      atk_coef      = ATTACK_RST;
      rel_coef      = RELEASE_RST;
      hold_samples  = HOLD_RST;
      power_avg     = '0;
      seeded        = 1'b0;
      gain_level    = GAIN_ONE;
      hold_cnt      = '0;
      errors        = 0;
      checked       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_TARGET:  tgt_lvl       = value[COEF_W-1:0];
        CFG_ATTACK:  atk_coef      = value[COEF_W-1:0];
        CFG_RELEASE: rel_coef      = value[COEF_W-1:0];
        CFG_HOLD:    hold_samples  = value[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] level_root(logic [31:0] v);
      logic [31:0] root;
      logic [31:0] bitv;
      root = '0;
      bitv = ROOT_BIT_TOP;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root[15:0];
    endfunction

    // Advance the gain state by one sample and queue the beat it must produce.
    function void take_sample(logic signed [SAMPLE_W-1:0] x);
      int              xi;
      logic [31:0]     mag;
      logic [31:0]     p;
      logic [63:0]     acc;
      logic [15:0]     rms;
      logic [GAIN_W-1:0] req;
      logic [16:0]     c;
      longint          prod;
      longint          y;
      agc_beat_t       beat;
      xi  = x;
      mag = (xi < 0) ? 32'(-xi) : 32'(xi);
      p   = mag * mag;
      if (!seeded) begin
        power_avg = p;
        seeded = 1'b1;
      end else begin
        acc = 64'(power_avg) * 64'(AVG_KEEP) + 64'(p) * 64'(AVG_NEW) + 64'd32768;
        power_avg = acc[47:16];
      end
      rms = level_root(power_avg);
      if (rms == 0) begin
        req = GAIN_ONE;
      end else begin
        acc = (64'(tgt_lvl) << 15) / 64'(rms);
        req = (acc > 64'(GAIN_MAX)) ? GAIN_MAX : acc[GAIN_W-1:0];
      end
      if (hold_cnt == 0) begin
        c = (req > gain_level) ? {1'b0, atk_coef} : {1'b0, rel_coef};
        acc = 64'(gain_level) * 64'(c) + 64'(req) * (64'(COEF_ONE) - 64'(c)) + 64'd32768;
        gain_level = acc[39:16];
      end
      prod = longint'(xi) * longint'({40'd0, gain_level}) + 64'sd32768;
      y = prod >>> 16;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      if (hold_cnt != 0) hold_cnt = hold_cnt - 1'b1;
      if (req < gain_level) hold_cnt = hold_samples;
      beat.sample_out = y[15:0];
      beat.gain_now   = gain_level;
      expected_beats.push_back(beat);
    endfunction

    function void check_output(logic [39:0] data);
      agc_beat_t got;
      agc_beat_t want;
      got = data;
      checked++;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual sample_out=%0d gain_now=%0d",
                 $time, $signed(got.sample_out), got.gain_now);
        return;
      end
      want = expected_beats.pop_front();
      if (got.sample_out !== want.sample_out) begin
        errors++;
        $display("%0t: sample_out expected %0d actual %0d", $time,
                 $signed(want.sample_out), $signed(got.sample_out));
      end
      if (got.gain_now !== want.gain_now) begin
        errors++;
        $display("%0t: gain_now expected %0d actual %0d", $time, want.gain_now, got.gain_now);
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;    // [15:0] sample_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [39:0]           out_tdata;        // [15:0] sample_out, [39:16] gain_now
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  agc_checker  sb = new();
  int          burst_left = 0;
  int unsigned quiet_cycles = 0;

  adaptive_gain_control u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_adaptive_gain_control: done, errors");
      $finish;
    end
  end

  // Receiver: switch between stall patterns; hold off once for a long stretch.
  initial begin
    int  mode;
    int  span;
    bit  held_off;
    held_off = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(posedge clk);
        if (!held_off && sb.checked >= HOLD_OFF_AT) begin
          held_off = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_sample(input logic [15:0] x, input bit last);
    int gap;
    in_tdata  <= x;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(x);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    if (last || gap > 0) in_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  // Write all four registers back to back, then one unused index; the upper nibble of 16-bit values is don't-care.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] tgt, input logic [CFG_DATA_W-1:0] atk,
                               input logic [CFG_DATA_W-1:0] rel, input logic [CFG_DATA_W-1:0] hold);
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_ATTACK, atk);
    write_reg(CFG_RELEASE, rel);
    write_reg(CFG_HOLD, hold);
    if ($urandom_range(0, 1)) write_reg(CFG_SPARE, 20'($urandom));
    else write_reg(CFG_TOP_IDX, 20'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  task automatic send_list(input logic [15:0] xs[$]);
    foreach (xs[i]) send_sample(xs[i], i == xs.size() - 1);
    drain();
  endtask

  function automatic logic [15:0] shape_sample(int unsigned level);
    int amp;
    if ($urandom_range(0, 31) == 0) return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
    if (level == 0) return 16'(int'($urandom_range(0, 2)) - 1);
    amp = 1 << (level - 1);
    return 16'(int'($urandom_range(0, 2 * amp - 1)) - amp);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coeff();
    logic [3:0] junk;
    junk = 4'($urandom);
    case ($urandom_range(0, 5))
      0: return {junk, 16'h0000};
      1: return {junk, 16'hFFFF};
      2: return {junk, 16'($urandom)};
      default: return {junk, 16'($urandom_range(60000, 65535))};
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_target();
    logic [3:0] junk;
    junk = 4'($urandom);
    case ($urandom_range(0, 7))
      0: return {junk, 16'h0000};
      1: return {junk, 16'hFFFF};
      2: return {junk, 16'($urandom)};
      default: return {junk, 16'($urandom_range(2000, 20000))};
    endcase
  endfunction

  initial begin
    int          seg_left;
    int unsigned seg_level;
    int          n;
    seg_left  = 0;
    seg_level = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Silence first: seed the average with zero, then tiny samples keep rms at zero.
    send_list('{16'd0, 16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd2});
    // Huge required gain with zero coefficients: gain jumps to the saturated value.
    load_settings(20'd65535, 20'd0, 20'd0, 20'd0);
    send_list('{16'd100, -16'sd100, 16'd127, -16'sd128, 16'd300, 16'd64});
    // Zero target drops the gain to zero at once.
    load_settings(20'd0, 20'd65535, 20'd0, 20'd0);
    send_list('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd16384, 16'hFFFF});
    // Slowest smoothing with a short hold.
    load_settings(20'd6554, 20'd65535, 20'd65535, 20'd3);
    send_list('{16'h7FFF, 16'h8000, 16'd20000, -16'sd20000, 16'd5, 16'd0});

    repeat (8) begin
      load_settings(pick_target(), pick_coeff(), pick_coeff(),
                    ($urandom_range(0, 1)) ? 20'd0 : 20'($urandom_range(1, 64)));
      n = 210;
      for (int i = 0; i < n; i++) begin
        if (seg_left == 0) begin
          seg_left  = $urandom_range(1, 60);
          seg_level = $urandom_range(0, 16);
        end
        seg_left--;
        send_sample(shape_sample(seg_level), i == n - 1);
      end
      drain();
    end

    // Longest hold last, since the count it loads outlives the run.
    load_settings(pick_target(), pick_coeff(), pick_coeff(), 20'hF_FFFF);
    for (int i = 0; i < 12; i++) send_sample(shape_sample($urandom_range(4, 16)), i == 11);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_adaptive_gain_control: done, clean");
    end else begin
      $display("tb_adaptive_gain_control: done, errors");
    end
    $finish;
  end

endmodule
